[hdl/slts_pkg.sv]
// Shared types and constants for the script lexer token scanner.
`timescale 1ns / 1ps

package slts_pkg;

    localparam int KIND_W  = 5;
    localparam int START_W = 24;
    localparam int LEN_W   = 24;
    localparam int LINE_W  = 20;
    localparam int ERR_W   = 2;
    localparam int BYTE_W  = 8;

    localparam int DEFAULT_POSITION_BITS = 24;
    localparam int DEFAULT_LINE_BITS     = 20;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_LPAREN = 5'd0;
    localparam logic [KIND_W-1:0] K_RPAREN = 5'd1;
    localparam logic [KIND_W-1:0] K_LBRACE = 5'd2;
    localparam logic [KIND_W-1:0] K_RBRACE = 5'd3;
    localparam logic [KIND_W-1:0] K_SEMI   = 5'd4;
    localparam logic [KIND_W-1:0] K_COMMA  = 5'd5;
    localparam logic [KIND_W-1:0] K_DOT    = 5'd6;
    localparam logic [KIND_W-1:0] K_MINUS  = 5'd7;
    localparam logic [KIND_W-1:0] K_PLUS   = 5'd8;
    localparam logic [KIND_W-1:0] K_SLASH  = 5'd9;
    localparam logic [KIND_W-1:0] K_STAR   = 5'd10;
    localparam logic [KIND_W-1:0] K_BANG   = 5'd11;
    localparam logic [KIND_W-1:0] K_BANG_EQ = 5'd12;
    localparam logic [KIND_W-1:0] K_STRING = 5'd19;
    localparam logic [KIND_W-1:0] K_NUMBER = 5'd20;
    localparam logic [KIND_W-1:0] K_ERROR  = 5'd21;
    localparam logic [KIND_W-1:0] K_EOF    = 5'd22;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNTERM_STR = 2'd2;

    // Operator codes held while the next byte is awaited.
    localparam logic [1:0] OP_BANG  = 2'd0;
    localparam logic [1:0] OP_EQUAL = 2'd1;
    localparam logic [1:0] OP_LESS  = 2'd2;
    localparam logic [1:0] OP_GREATER = 2'd3;

    // Characters.
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_LESS   = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_GREATER = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

    localparam int RUN_MAX = 3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [LINE_W-1:0]  line;
        logic [ERR_W-1:0]   err;
    } token_t;

    // All tokens caused by one input byte, in order.
    typedef struct packed {
        logic [1:0]              count;
        token_t [RUN_MAX-1:0]    tok;
    } bundle_t;

endpackage

[hdl/slts_front.sv]
// Scanner front end: accepts source bytes and forms the token run of each byte.
`timescale 1ns / 1ps

module slts_front #(
    parameter int POSITION_BITS = slts_pkg::DEFAULT_POSITION_BITS,
    parameter int LINE_BITS     = slts_pkg::DEFAULT_LINE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [slts_pkg::BYTE_W-1:0]   s_source_byte,
    input  logic                          s_end_of_source,
    output logic                          push_valid,
    output slts_pkg::bundle_t             push_data,
    input  logic                          push_ready
);
    import slts_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int LB = LINE_BITS;
    localparam int PW = (PB + 1 > START_W) ? PB + 1 : START_W;
    localparam int LW = (LB > LINE_W) ? LB : LINE_W;
    localparam logic [PB-1:0] POS_MAX  = {PB{1'b1}};
    localparam logic [LB-1:0] LINE_MAX = {LB{1'b1}};
    localparam logic [LB-1:0] LINE_ONE = LB'(1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPERATOR,
        PH_SLASH,
        PH_COMMENT,
        PH_INT,
        PH_INT_DOT,
        PH_FRAC,
        PH_STRING
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [1:0]    op_reg, op_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] ls_reg, ls_next;
    logic [LB-1:0] line_reg, line_next;

    logic          accept;
    logic          eos;
    logic [PB:0]   p1, l1;
    logic [PB:0]   dot_p;
    logic          is_digit;
    logic          run_idle;
    logic          bump;
    logic [1:0]    fc, fcp;
    logic          ev;
    token_t        f0, f1, e;
    logic [1:0]    count;

    function automatic logic [START_W-1:0] fit_pos(input logic [PB:0] v);
        logic [PW-1:0] w;
        w = PW'(v);
        return w[START_W-1:0];
    endfunction

    function automatic token_t mk(input logic [KIND_W-1:0] kind, input logic [PB:0] start,
                                  input logic [PB:0] len, input logic [ERR_W-1:0] err);
        token_t t;
        logic [LW-1:0] lw;
        lw = LW'(line_reg);
        t.kind   = kind;
        t.start  = fit_pos(start);
        t.length = fit_pos(len);
        t.line   = lw[LINE_W-1:0];
        t.err    = err;
        return t;
    endfunction

    assign s_ready = push_ready;
    assign accept  = s_valid & push_ready;
    assign eos     = s_end_of_source | (s_source_byte == CH_NUL);
    assign p1      = {1'b0, pos_reg};
    assign l1      = {1'b0, ls_reg};
    assign dot_p   = p1 - (PB+1)'(1);
    assign is_digit = (s_source_byte inside {[CH_0:CH_9]});

    // Tokens that the pending lexeme yields if it is cut off at this byte.
    always_comb begin
        fcp = 2'd0;
        f0  = '0;
        f1  = '0;
        case (phase_reg)
            PH_OPERATOR: begin
                fcp = 2'd1;
                f0  = mk(K_BANG + {2'b00, op_reg, 1'b0}, l1, p1 - l1, ERR_NONE);
            end
            PH_SLASH: begin
                fcp = 2'd1;
                f0  = mk(K_SLASH, l1, p1 - l1, ERR_NONE);
            end
            PH_INT, PH_FRAC: begin
                fcp = 2'd1;
                f0  = mk(K_NUMBER, l1, p1 - l1, ERR_NONE);
            end
            PH_INT_DOT: begin
                // The held dot becomes a token of its own. Once the position has
                // saturated the dot can sit at the number's start, so the number
                // length floors at zero.
                fcp = 2'd2;
                f0  = mk(K_NUMBER, l1, (dot_p >= l1) ? dot_p - l1 : '0, ERR_NONE);
                f1  = mk(K_DOT, dot_p, (PB+1)'(1), ERR_NONE);
            end
            PH_STRING: begin
                fcp = 2'd1;
                f0  = mk(K_ERROR, l1, p1 - l1, ERR_UNTERM_STR);
            end
            default: begin
                fcp = 2'd0;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        ls_next    = ls_reg;
        fc         = 2'd0;
        ev         = 1'b0;
        e          = '0;
        run_idle   = 1'b0;
        bump       = 1'b0;

        if (!eos) begin
            case (phase_reg)
                PH_OPERATOR: begin
                    if (s_source_byte == CH_EQUAL) begin
                        ev = 1'b1;
                        e  = mk(K_BANG_EQ + {2'b00, op_reg, 1'b0}, l1,
                                p1 + (PB+1)'(1) - l1, ERR_NONE);
                        phase_next = PH_IDLE;
                    end else begin
                        run_idle = 1'b1;
                    end
                end
                PH_SLASH: begin
                    if (s_source_byte == CH_SLASH) phase_next = PH_COMMENT;
                    else run_idle = 1'b1;
                end
                PH_COMMENT: begin
                    if (s_source_byte == CH_LF) begin
                        phase_next = PH_IDLE;
                        bump       = 1'b1;
                    end
                end
                PH_INT: begin
                    if (s_source_byte == CH_DOT) phase_next = PH_INT_DOT;
                    else if (!is_digit) run_idle = 1'b1;
                end
                PH_INT_DOT: begin
                    if (is_digit) phase_next = PH_FRAC;
                    else run_idle = 1'b1;
                end
                PH_FRAC: begin
                    if (!is_digit) run_idle = 1'b1;
                end
                PH_STRING: begin
                    if (s_source_byte == CH_QUOTE) begin
                        ev = 1'b1;
                        e  = mk(K_STRING, l1, p1 + (PB+1)'(1) - l1, ERR_NONE);
                        phase_next = PH_IDLE;
                    end else if (s_source_byte == CH_LF) begin
                        bump = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_idle) begin
                fc         = fcp;
                phase_next = PH_IDLE;
                ev         = 1'b1;
                case (s_source_byte)
                    CH_SPACE, CH_CR, CH_TAB: ev = 1'b0;
                    CH_LF: begin
                        ev   = 1'b0;
                        bump = 1'b1;
                    end
                    CH_LPAREN: e = mk(K_LPAREN, p1, (PB+1)'(1), ERR_NONE);
                    CH_RPAREN: e = mk(K_RPAREN, p1, (PB+1)'(1), ERR_NONE);
                    CH_LBRACE: e = mk(K_LBRACE, p1, (PB+1)'(1), ERR_NONE);
                    CH_RBRACE: e = mk(K_RBRACE, p1, (PB+1)'(1), ERR_NONE);
                    CH_SEMI:   e = mk(K_SEMI,   p1, (PB+1)'(1), ERR_NONE);
                    CH_COMMA:  e = mk(K_COMMA,  p1, (PB+1)'(1), ERR_NONE);
                    CH_DOT:    e = mk(K_DOT,    p1, (PB+1)'(1), ERR_NONE);
                    CH_MINUS:  e = mk(K_MINUS,  p1, (PB+1)'(1), ERR_NONE);
                    CH_PLUS:   e = mk(K_PLUS,   p1, (PB+1)'(1), ERR_NONE);
                    CH_STAR:   e = mk(K_STAR,   p1, (PB+1)'(1), ERR_NONE);
                    CH_SLASH: begin
                        ev = 1'b0;
                        ls_next = pos_reg;
                        phase_next = PH_SLASH;
                    end
                    CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER: begin
                        ev = 1'b0;
                        ls_next = pos_reg;
                        phase_next = PH_OPERATOR;
                        case (s_source_byte)
                            CH_BANG:  op_next = OP_BANG;
                            CH_EQUAL: op_next = OP_EQUAL;
                            CH_LESS:  op_next = OP_LESS;
                            default:  op_next = OP_GREATER;
                        endcase
                    end
                    CH_QUOTE: begin
                        ev = 1'b0;
                        ls_next = pos_reg;
                        phase_next = PH_STRING;
                    end
                    default: begin
                        if (is_digit) begin
                            ev = 1'b0;
                            ls_next = pos_reg;
                            phase_next = PH_INT;
                        end else begin
                            e = mk(K_ERROR, p1, (PB+1)'(1), ERR_UNEXPECTED);
                        end
                    end
                endcase
            end
        end else begin
            // End of source: flush, report EOF, then start over.
            fc         = fcp;
            ev         = 1'b1;
            e          = mk(K_EOF, p1, '0, ERR_NONE);
            phase_next = PH_IDLE;
            op_next    = OP_BANG;
            ls_next    = '0;
        end
    end

    always_comb begin
        if (eos) begin
            pos_next  = '0;
            line_next = LINE_ONE;
        end else begin
            pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + PB'(1);
            line_next = (bump && line_reg != LINE_MAX) ? line_reg + LB'(1) : line_reg;
        end
    end

    // Pack the flushed tokens first and the byte's own token after them.
    always_comb begin
        count = fc + {1'b0, ev};
        push_data.count = count;
        push_data.tok[2] = e;
        case (fc)
            2'd0: begin
                push_data.tok[0] = e;
                push_data.tok[1] = '0;
            end
            2'd1: begin
                push_data.tok[0] = f0;
                push_data.tok[1] = e;
            end
            default: begin
                push_data.tok[0] = f0;
                push_data.tok[1] = f1;
            end
        endcase
    end

    assign push_valid = accept && (count != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            op_reg    <= OP_BANG;
            pos_reg   <= '0;
            ls_reg    <= '0;
            line_reg  <= LINE_ONE;
        end else if (accept) begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            pos_reg   <= pos_next;
            ls_reg    <= ls_next;
            line_reg  <= line_next;
        end
    end

endmodule

[hdl/slts_queue.sv]
// Two-entry queue of token runs between the scanner front end and the output stage.
`timescale 1ns / 1ps

module slts_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  slts_pkg::bundle_t push_data,
    output logic              push_ready,
    output logic              pop_valid,
    output slts_pkg::bundle_t pop_data,
    input  logic              pop
);
    import slts_pkg::*;

    localparam int DEPTH = 2;

    bundle_t     entry_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/slts_back.sv]
// Output stage: sends the tokens of each queued run one transfer at a time.
`timescale 1ns / 1ps

module slts_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  slts_pkg::bundle_t             q_data,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [slts_pkg::KIND_W-1:0]   m_token_kind,
    output logic [slts_pkg::START_W-1:0]  m_token_start,
    output logic [slts_pkg::LEN_W-1:0]    m_token_length,
    output logic [slts_pkg::LINE_W-1:0]   m_token_line,
    output logic [slts_pkg::ERR_W-1:0]    m_error_kind,
    output logic                          m_last_of_run
);
    import slts_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    token_t     tok_reg;
    logic       last_reg;
    logic       load;
    logic       is_last;
    token_t     cur;

    assign load    = q_valid && (!valid_reg || m_ready);
    assign cur     = q_data.tok[idx_reg];
    assign is_last = (idx_reg + 2'd1 == q_data.count);
    assign q_pop   = load && is_last;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= cur;
            last_reg <= is_last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = tok_reg.kind;
    assign m_token_start  = tok_reg.start;
    assign m_token_length = tok_reg.length;
    assign m_token_line   = tok_reg.line;
    assign m_error_kind   = tok_reg.err;
    assign m_last_of_run  = last_reg;

endmodule

[hdl/script_lexer_token_scanner.sv]
// Top level of the script lexer token scanner: front end, run queue, output stage.
// A byte's first token is registered in the run queue, then in the output stage, before
// it shows on the m_ side. Throughput is one byte per cycle while m_ready is high and
// each byte yields at most one token; a byte that yields several tokens holds the output
// stage for one transfer per token, and the two-entry run queue absorbs such bursts.
// Reset (aresetn low) clears scan phase, positions and queue and sets the line count to 1.
`timescale 1ns / 1ps

module script_lexer_token_scanner #(
    parameter int POSITION_BITS = slts_pkg::DEFAULT_POSITION_BITS,
    parameter int LINE_BITS     = slts_pkg::DEFAULT_LINE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [slts_pkg::BYTE_W-1:0]   s_source_byte,
    input  logic                          s_end_of_source,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [slts_pkg::KIND_W-1:0]   m_token_kind,
    output logic [slts_pkg::START_W-1:0]  m_token_start,
    output logic [slts_pkg::LEN_W-1:0]    m_token_length,
    output logic [slts_pkg::LINE_W-1:0]   m_token_line,
    output logic [slts_pkg::ERR_W-1:0]    m_error_kind,
    output logic                          m_last_of_run
);
    import slts_pkg::*;

    logic    push_valid, push_ready;
    bundle_t push_data;
    logic    q_valid, q_pop;
    bundle_t q_data;

    slts_front #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_byte   (s_source_byte),
        .s_end_of_source (s_end_of_source),
        .push_valid      (push_valid),
        .push_data       (push_data),
        .push_ready      (push_ready)
    );

    slts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (q_pop)
    );

    slts_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_token_line   (m_token_line),
        .m_error_kind   (m_error_kind),
        .m_last_of_run  (m_last_of_run)
    );

endmodule
